@@ rtl/core/icdf_pkg.sv @@
// Package: shared types, codes and sizes of the inverse-CDF table sampler.
`timescale 1ns / 1ps
package icdf_pkg;
	localparam int NUM_SPECTRA_DEF = 4;
	localparam int POINTS_DEF      = 256;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [2:0] AS_LAST = 3'd0;
	localparam logic [2:0] AS_MID  = 3'd1;
	localparam logic [2:0] AS_LO   = 3'd2;
	localparam logic [2:0] AS_PREV = 3'd3;
	localparam logic [2:0] AS_NEXT = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [1:0]  spectrum;
		logic [23:0] point_energy_in;
		logic [15:0] point_density;
		logic [15:0] uniform;
	} in_t;

	typedef struct packed {
		logic [23:0] sampled_energy;
		logic [1:0]  status;
	} out_t;

	typedef struct packed {
		logic       load;
		logic [2:0] addr_sel;
		logic       wr;
		logic       clear_cnt;
		logic       latch_total;
		logic       search_init;
		logic       search_step;
		logic       latch_i;
		logic       latch_p;
		logic       div_init;
		logic       div_step;
		logic       finish;
		logic [1:0] code;
		logic       put_energy;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       bad;
		logic       empty;
		logic       full;
		logic       total_zero;
		logic       search_done;
		logic       lo_zero;
		logic       div_done;
	} sts_t;
endpackage

@@ rtl/core/icdf_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module icdf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/core/icdf_ctrl.sv @@
// Controller state machine of the inverse-CDF table sampler.
`timescale 1ns / 1ps
module icdf_ctrl import icdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_APWR = 4'd2;
	localparam logic [3:0] S_TOT  = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_SRCH = 4'd5;
	localparam logic [3:0] S_CMP  = 4'd6;
	localparam logic [3:0] S_RDI  = 4'd7;
	localparam logic [3:0] S_RDP  = 4'd8;
	localparam logic [3:0] S_LATP = 4'd9;
	localparam logic [3:0] S_DIVI = 4'd10;
	localparam logic [3:0] S_DIV  = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.addr_sel = AS_LAST;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_CLEAR: begin
						cmd.clear_cnt = !sts.bad;
						cmd.finish = 1'b1;
						cmd.code = ST_OK;
						state_d = S_IDLE;
					end
					OP_APPEND: begin
						if (sts.bad || sts.full) begin
							cmd.finish = 1'b1;
							cmd.code = ST_FULL;
							state_d = S_IDLE;
						end else begin
							state_d = S_APWR;
						end
					end
					OP_SAMPLE: begin
						if (sts.bad || sts.empty) begin
							cmd.finish = 1'b1;
							cmd.code = ST_EMPTY;
							state_d = S_IDLE;
						end else begin
							state_d = S_TOT;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						cmd.code = ST_OK;
						state_d = S_IDLE;
					end
				endcase
			end
			S_APWR: begin
				cmd.addr_sel = AS_NEXT;
				cmd.wr = 1'b1;
				cmd.finish = 1'b1;
				cmd.code = ST_OK;
				state_d = S_IDLE;
			end
			S_TOT: begin
				cmd.latch_total = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (sts.total_zero) begin
					cmd.finish = 1'b1;
					cmd.code = ST_EMPTY;
					state_d = S_IDLE;
				end else begin
					cmd.search_init = 1'b1;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				cmd.addr_sel = AS_MID;
				state_d = sts.search_done ? S_RDI : S_CMP;
			end
			S_CMP: begin
				cmd.search_step = 1'b1;
				state_d = S_SRCH;
			end
			S_RDI: begin
				cmd.addr_sel = AS_LO;
				state_d = S_RDP;
			end
			S_RDP: begin
				cmd.addr_sel = AS_PREV;
				cmd.latch_i = 1'b1;
				state_d = sts.lo_zero ? S_DIVI : S_LATP;
			end
			S_LATP: begin
				cmd.latch_p = 1'b1;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d = sts.div_done ? S_FIN : S_DIV;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				cmd.code = ST_OK;
				cmd.put_energy = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ rtl/core/icdf_dp.sv @@
// Datapath: tables, point counts, search, interpolation divider, result register.
`timescale 1ns / 1ps
module icdf_dp import icdf_pkg::*; #(
	parameter int NUM_SPECTRA         = NUM_SPECTRA_DEF,
	parameter int POINTS_PER_SPECTRUM = POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  in_t  item,
	input  cmd_t cmd,
	output sts_t sts,
	output out_t result,
	output logic done
);
	localparam int DEPTH = NUM_SPECTRA * POINTS_PER_SPECTRUM;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(POINTS_PER_SPECTRUM);
	localparam int CW = $clog2(POINTS_PER_SPECTRUM + 1);
	localparam int SW = (NUM_SPECTRA > 1) ? $clog2(NUM_SPECTRA) : 1;

	in_t item_q;
	logic [CW-1:0] cnt_q [NUM_SPECTRA];
	logic [23:0] total_q, xi_q, xp_q, fi_q, fp_q, mul_q, q_q, xbase_q;
	logic [39:0] target_q, num_q, den_q;
	logic [41:0] r_q;
	logic [PW-1:0] lo_q, hi_q;
	logic [4:0] bit_q;
	logic neg_q, done_q;
	out_t result_q;

	logic [SW-1:0] sidx;
	logic bad;
	logic [CW-1:0] cnt_sel;
	logic [PW:0] mid_sum;
	logic [PW-1:0] mid, idx;
	logic [AW-1:0] addr;
	logic [23:0] e_rd, c_rd, prev_c;
	logic [24:0] sum25;
	logic [23:0] sum_sat;
	logic [41:0] r1, r2, r3;
	logic [23:0] q1, q2;
	logic [23:0] energy;

	assign sidx = SW'(item_q.spectrum);
	assign bad = ({30'd0, item_q.spectrum} >= NUM_SPECTRA);
	assign cnt_sel = bad ? '0 : cnt_q[sidx];
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = PW'(mid_sum >> 1);

	always_comb begin
		unique case (cmd.addr_sel)
			AS_LAST: idx = PW'(cnt_sel - CW'(1));
			AS_MID:  idx = mid;
			AS_LO:   idx = lo_q;
			AS_PREV: idx = lo_q - PW'(1);
			AS_NEXT: idx = PW'(cnt_sel);
			default: idx = lo_q;
		endcase
	end

	assign addr = AW'(AW'(sidx) * AW'(POINTS_PER_SPECTRUM)) + AW'(idx);

	assign prev_c = (cnt_sel == '0) ? 24'd0 : c_rd;
	assign sum25 = {1'b0, prev_c} + {9'd0, item_q.point_density};
	assign sum_sat = sum25[24] ? 24'hFFFFFF : sum25[23:0];

	icdf_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_energy (
		.clk(clk), .we(cmd.wr), .addr(addr),
		.wdata(item_q.point_energy_in), .rdata(e_rd)
	);

	icdf_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_cum (
		.clk(clk), .we(cmd.wr), .addr(addr),
		.wdata(sum_sat), .rdata(c_rd)
	);

	always_comb begin
		r1 = {r_q[40:0], 1'b0};
		q1 = {q_q[22:0], 1'b0};
		if (r1 >= {2'd0, den_q}) begin
			r1 = r1 - {2'd0, den_q};
			q1 = q1 + 24'd1;
		end
		r2 = r1;
		q2 = q1;
		if (mul_q[bit_q]) begin
			r3 = r1 + {2'd0, num_q};
			if (r3 >= {2'd0, den_q}) begin
				r2 = r3 - {2'd0, den_q};
				q2 = q1 + 24'd1;
			end else begin
				r2 = r3;
			end
		end else begin
			r3 = r1;
		end
	end

	assign energy = neg_q ? (xbase_q - q_q) : (xbase_q + q_q);

	assign sts.op = item_q.operation;
	assign sts.bad = bad;
	assign sts.empty = (cnt_sel == '0);
	assign sts.full = (cnt_sel >= CW'(POINTS_PER_SPECTRUM));
	assign sts.total_zero = (total_q == 24'd0);
	assign sts.search_done = (lo_q == hi_q);
	assign sts.lo_zero = (lo_q == '0);
	assign sts.div_done = (bit_q == 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.latch_total) begin
			total_q <= c_rd;
		end
		if (cmd.search_init) begin
			target_q <= 40'(item_q.uniform * total_q);
			lo_q <= '0;
			hi_q <= PW'(cnt_sel - CW'(1));
		end
		if (cmd.search_step) begin
			if ({c_rd, 16'd0} > target_q) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + PW'(1);
			end
		end
		if (cmd.latch_i) begin
			xi_q <= e_rd;
			fi_q <= c_rd;
			xp_q <= 24'd0;
			fp_q <= 24'd0;
		end
		if (cmd.latch_p) begin
			xp_q <= e_rd;
			fp_q <= c_rd;
		end
		if (cmd.div_init) begin
			num_q <= target_q - {fp_q, 16'd0};
			den_q <= {fi_q - fp_q, 16'd0};
			neg_q <= (xi_q < xp_q);
			mul_q <= (xi_q < xp_q) ? (xp_q - xi_q) : (xi_q - xp_q);
			xbase_q <= xp_q;
			r_q <= '0;
			q_q <= '0;
			bit_q <= 5'd23;
		end
		if (cmd.div_step) begin
			r_q <= r2;
			q_q <= q2;
			bit_q <= bit_q - 5'd1;
		end
		if (cmd.finish) begin
			result_q.status <= cmd.code;
			result_q.sampled_energy <= cmd.put_energy ? energy : 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			for (int k = 0; k < NUM_SPECTRA; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			done_q <= cmd.finish;
			if (cmd.clear_cnt) begin
				cnt_q[sidx] <= '0;
			end
			if (cmd.wr) begin
				cnt_q[sidx] <= cnt_sel + CW'(1);
			end
		end
	end

	assign result = result_q;
	assign done = done_q;
endmodule

@@ rtl/core/inverse_cdf_table_sampler_unit.sv @@
// Top level of the inverse-CDF table sampler.
//
// channel   ports               handshake
// input     start, busy, item   taken when start is high and busy is low
// result    done, result        done high for one cycle per item
//
// The time a sample takes is set by the binary search over the cumulative table
// RAM (each probe reads the middle entry, then compares it) and the 24-step
// bit-serial divider.
// arst_n clears all point counts; table contents are undefined until written.
// busy holds the input off while an item is at work; results cannot be stalled.
`timescale 1ns / 1ps
module inverse_cdf_table_sampler_unit import icdf_pkg::*; #(
	parameter int NUM_SPECTRA         = NUM_SPECTRA_DEF,
	parameter int POINTS_PER_SPECTRUM = POINTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  item,
	output logic done,
	output out_t result
);
	cmd_t cmd;
	sts_t sts;

	icdf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	icdf_dp #(
		.NUM_SPECTRA(NUM_SPECTRA),
		.POINTS_PER_SPECTRUM(POINTS_PER_SPECTRUM)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cmd(cmd),
		.sts(sts), .result(result), .done(done)
	);
endmodule
